/* hdl/moving_average_warmup_assert.svh */
// Assertion macros shared by the moving average RTL.
// Needs clk and rst_n in the including module.
`ifndef MOVING_AVERAGE_WARMUP_ASSERT_SVH
`define MOVING_AVERAGE_WARMUP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MAVG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the following cycle
`define MAVG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mavg_pkg.sv */
// Shared types and constants for the moving average block.
// No dependencies.
package mavg_pkg;

  localparam int unsigned MAVG_WINDOW_MAX  = 256;
  localparam int unsigned MAVG_SAMPLE_BITS = 32;
  localparam int unsigned SUM_W            = 40;
  localparam int unsigned WORD_W           = 32;
  localparam int unsigned CFG_LEN_W        = 9;
  localparam int unsigned CFG_DATA_W       = 32;
  localparam int unsigned CFG_ADDR_W       = 2;

  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_LEN  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PRELOAD_EN  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PRELOAD_VAL = 2'd2;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_FILL,
    ST_WARM,
    ST_RD,
    ST_SUB,
    ST_ADD,
    ST_DIV_GO,
    ST_DIV,
    ST_DONE
  } mavg_state_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* hdl/moving_average_warmup.sv */
// Moving average with warm-up. A sample word's result comes from the 40-step shared
// divider, both during warm-up and once the window is full; ready rises with the result,
// so the next word can be taken in the same cycle as the result at the earliest.
// A plain restart answers after clearing the window state, a preloading one after writing
// window length store entries (one store entry written per cycle); a stalled result holds
// the block. rst_n is synchronous, active low; the window store is not cleared by reset.
module moving_average_warmup #(
  parameter int unsigned WINDOW_MAX  = mavg_pkg::MAVG_WINDOW_MAX,
  parameter int unsigned SAMPLE_BITS = mavg_pkg::MAVG_SAMPLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mavg_pkg::WORD_W-1:0]     in_tdata,   // [31:0] sample
  input  logic [0:0]                      in_tuser,   // [0] op
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mavg_pkg::WORD_W-1:0]     out_tdata,  // [31:0] average
  output logic [0:0]                      out_tuser,  // [0] warming_up
  input  logic                            cfg_we,
  input  logic [mavg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mavg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mavg_pkg::*;
`include "moving_average_warmup_assert.svh"

  localparam int unsigned LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int unsigned PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned INC_W = LEN_W + 1;
  localparam logic [SAMPLE_BITS-1:0] SMASK = {SAMPLE_BITS{1'b1}};

  // configuration
  logic [CFG_LEN_W-1:0]   window_len_r;
  logic                   preload_en_r;
  logic [CFG_DATA_W-1:0]  preload_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r  <= CFG_LEN_W'(8);
      preload_en_r  <= 1'b0;
      preload_val_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_WINDOW_LEN:  window_len_r  <= cfg_wdata[CFG_LEN_W-1:0];
        CFG_PRELOAD_EN:  preload_en_r  <= cfg_wdata[0];
        CFG_PRELOAD_VAL: preload_val_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mavg_state_t state_r, state_nxt;

  logic                   op_r, op_nxt;
  logic [SAMPLE_BITS-1:0] smp_r, smp_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [LEN_W-1:0]       fill_r, fill_nxt;
  logic [PTR_W-1:0]       wp_r, wp_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SAMPLE_BITS-1:0] avg_r, avg_nxt;
  logic [LEN_W-1:0]       idx_r, idx_nxt;
  logic [LEN_W-1:0]       den_r, den_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_avg_r, out_avg_nxt;
  logic                   out_warm_r, out_warm_nxt;

  logic                   in_acc;
  logic                   out_free;
  logic [LEN_W-1:0]       eff_len;
  logic [SAMPLE_BITS-1:0] pre_val;
  logic [INC_W-1:0]       wp_inc;
  logic [PTR_W-1:0]       wp_new;

  // window store
  logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
  logic                   mem_we;
  logic [PTR_W-1:0]       mem_waddr;
  logic [SAMPLE_BITS-1:0] mem_wdata;
  logic [SAMPLE_BITS-1:0] rd_data_r;

  // shared accumulator adder
  logic [SUM_W-1:0]       alu_b;
  logic                   alu_sub;
  logic [SUM_W-1:0]       alu_res;

  div_req_t               div_req;
  div_rsp_t               div_rsp;
  logic [SAMPLE_BITS-1:0] quot_sat;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign pre_val   = preload_val_r[SAMPLE_BITS-1:0];

  always_comb begin
    if (window_len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(window_len_r) > 32'(WINDOW_MAX)) begin
      eff_len = LEN_W'(WINDOW_MAX);
    end else begin
      eff_len = LEN_W'(window_len_r);
    end
  end

  assign wp_inc = INC_W'(wp_r) + INC_W'(1);
  assign wp_new = (wp_inc >= INC_W'(len_r)) ? '0 : wp_inc[PTR_W-1:0];

  assign alu_res  = alu_sub ? (sum_r - alu_b) : (sum_r + alu_b);
  assign quot_sat = (div_rsp.quotient > SUM_W'(SMASK)) ? SMASK
                                                         : div_rsp.quotient[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[wp_new];
  end

  mavg_div #(
    .DEN_W (LEN_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .divisor (den_r),
    .rsp     (div_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0] == OP_RESTART) begin
            state_nxt = preload_en_r ? ST_FILL : ST_CLR;
          end else if (fill_r < eff_len) begin
            state_nxt = ST_WARM;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_CLR:    state_nxt = ST_DONE;
      ST_FILL: begin
        if (idx_r == len_r - LEN_W'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_WARM:   state_nxt = ST_DIV_GO;
      ST_RD:     state_nxt = ST_SUB;
      ST_SUB:    state_nxt = ST_ADD;
      ST_ADD:    state_nxt = ST_DIV_GO;
      ST_DIV_GO: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    op_nxt        = op_r;
    smp_nxt       = smp_r;
    len_nxt       = len_r;
    fill_nxt      = fill_r;
    wp_nxt        = wp_r;
    sum_nxt       = sum_r;
    avg_nxt       = avg_r;
    idx_nxt       = idx_r;
    den_nxt       = den_r;
    out_avg_nxt   = out_avg_r;
    out_warm_nxt  = out_warm_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mem_we        = 1'b0;
    mem_waddr     = wp_r;
    mem_wdata     = smp_r;
    alu_b         = SUM_W'(smp_r);
    alu_sub       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = sum_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt  = in_tuser[0];
          smp_nxt = in_tdata[SAMPLE_BITS-1:0];
          len_nxt = eff_len;
          idx_nxt = '0;
          if (in_tuser[0] == OP_RESTART) begin
            sum_nxt = '0;
          end
        end
      end
      ST_CLR: begin
        fill_nxt = '0;
        wp_nxt   = '0;
        avg_nxt  = '0;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[PTR_W-1:0];
        mem_wdata = pre_val;
        alu_b     = SUM_W'(pre_val);
        sum_nxt   = alu_res;
        idx_nxt   = idx_r + LEN_W'(1);
        if (idx_r == len_r - LEN_W'(1)) begin
          fill_nxt = len_r;
          wp_nxt   = '0;
          avg_nxt  = pre_val;
        end
      end
      ST_WARM: begin
        mem_we    = 1'b1;
        mem_waddr = fill_r[PTR_W-1:0];
        sum_nxt   = alu_res;
        wp_nxt    = fill_r[PTR_W-1:0];
        fill_nxt  = fill_r + LEN_W'(1);
        den_nxt   = fill_r + LEN_W'(1);
      end
      ST_RD: begin
        wp_nxt = wp_new;
      end
      ST_SUB: begin
        alu_b   = SUM_W'(rd_data_r);
        alu_sub = 1'b1;
        sum_nxt = alu_res;
      end
      ST_ADD: begin
        mem_we  = 1'b1;
        sum_nxt = alu_res;
        den_nxt = len_r;
      end
      ST_DIV_GO: begin
        div_req.start = 1'b1;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          avg_nxt = quot_sat;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = avg_r;
          out_warm_nxt  = fill_r < len_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      wp_r        <= '0;
      sum_r       <= '0;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      wp_r        <= wp_nxt;
      sum_r       <= sum_nxt;
      avg_r       <= avg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    smp_r      <= smp_nxt;
    len_r      <= len_nxt;
    idx_r      <= idx_nxt;
    den_r      <= den_nxt;
    out_avg_r  <= out_avg_nxt;
    out_warm_r <= out_warm_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = WORD_W'(out_avg_r);
  assign out_tuser[0] = out_warm_r;

  `MAVG_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_tready, "ready held after accepting a word")
  `MAVG_ASSERT_SAME(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
  `MAVG_ASSERT_SAME(a_div_done_state, div_rsp.done, state_r == ST_DIV, "divider result unexpected")
  `MAVG_ASSERT_SAME(a_op_sample_div, state_r == ST_DIV_GO, op_r == OP_SAMPLE, "restart sent to divider")
  `MAVG_ASSERT_NEXT(a_result_loaded, (state_r == ST_DONE) && out_free, out_tvalid, "result not presented")

endmodule

/* hdl/mavg_div.sv */
// Restoring divider, one quotient bit per cycle, SUM_W quotient bits per division.
// Depends on mavg_pkg.
module mavg_div #(
  parameter int unsigned DEN_W = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mavg_pkg::div_req_t req,
  input  logic [DEN_W-1:0]   divisor,
  output mavg_pkg::div_rsp_t rsp
);
  import mavg_pkg::*;

  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, q_r[SUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(SUM_W);
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      q_nxt   = {q_r[SUM_W-2:0], ge};
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule
